// ===== design/pmas_pkg.sv =====
// shared constants and types for the power meter autorange step block
`timescale 1ns / 1ps
package pmas_pkg;

  localparam int unsigned CFG_VOFS = 0;
  localparam int unsigned CFG_IOFS = 1;
  localparam int unsigned CFG_FSTART = 2;
  localparam int unsigned CFG_FFULL = 3;

  localparam logic [16:0] V_NUM = 17'd97506;
  localparam logic [16:0] V_DEN = 17'd100000;

  // multiplier operand selects, one per scaled quantity
  typedef enum logic [2:0] {
    MUL_VOLT,
    MUL_CURR,
    MUL_POWER,
    MUL_DUTY,
    MUL_GAIN
  } mul_sel_e;

  // current scale factor per gain code
  function automatic logic [16:0] curr_num(input logic [1:0] g);
    logic [16:0] r;
    unique case (g)
      2'd0: r = 17'd54349;
      2'd1: r = 17'd27175;
      2'd2: r = 17'd13587;
      default: r = 17'd67937;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] curr_den(input logic [1:0] g);
    return (g == 2'd3) ? 17'd100000 : 17'd10000;
  endfunction

  // divisor of each quantity
  function automatic logic [16:0] op_den(input mul_sel_e op, input logic [1:0] g);
    logic [16:0] r;
    unique case (op)
      MUL_VOLT: r = V_DEN;
      MUL_CURR: r = curr_den(g);
      MUL_POWER: r = 17'd1000;
      MUL_DUTY: r = 17'd30000;
      default: r = 17'h7FFF;
    endcase
    return r;
  endfunction

  // floor(2^41 / divisor), paired with the numerator shifted right by 9
  function automatic logic [31:0] op_recip(input mul_sel_e op, input logic [1:0] g);
    logic [31:0] r;
    unique case (op)
      MUL_VOLT: r = 32'd21990232;
      MUL_CURR: r = (g == 2'd3) ? 32'd21990232 : 32'd219902325;
      MUL_POWER: r = 32'd2199023255;
      MUL_DUTY: r = 32'd73300775;
      default: r = 32'd67110912;
    endcase
    return r;
  endfunction

endpackage

// ===== design/pmas_mul.sv =====
// shared registered multiplier, operands up to 32 by 32 unsigned
`timescale 1ns / 1ps
module pmas_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end
  assign p_o = p_q;
endmodule

// ===== design/pmas_div.sv =====
// quotient correction: steps an estimated quotient up until the remainder is below the divisor
`timescale 1ns / 1ps
module pmas_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] num_i,
  input  logic [47:0] prod_i,
  input  logic [31:0] quo_i,
  input  logic [16:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [19:0] r_q;
  logic [31:0] q_q;
  logic [16:0] den_q;
  logic        busy_q;
  logic [47:0] rem0;

  // estimate is at most two short, so the remainder stays below three divisors
  assign rem0 = num_i - prod_i;
  assign done_o = busy_q && (r_q < {3'b000, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      if (start_i) busy_q <= 1'b1;
      else if (done_o) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= rem0[19:0];
      q_q <= quo_i;
      den_q <= den_i;
    end else if (busy_q && !done_o) begin
      r_q <= r_q - {3'b000, den_q};
      q_q <= q_q + 32'd1;
    end
  end

  assign quo_o = q_q;
endmodule

// ===== design/power_meter_autorange_step_top.sv =====
// top level of the power meter autorange step block
`timescale 1ns / 1ps
// usage:
// one signed converter sample enters on sample_i with valid_i/ready_o.
// items alternate voltage phase and current phase, starting with voltage.
// each request gives one result on the output channel (valid_o/ready_i),
// carrying the held voltage, current, power, fan duty, next channel and
// gain, and change flags.
// all work runs through one shared registered multiplier: each scaled
// quantity takes a product pass, a reciprocal pass and a remainder pass,
// then correction steps until the remainder is below the divisor.
// a voltage request computes the voltage alone; a current request computes
// current, power, duty and gain in turn before valid_o rises.
// ready_o is low from acceptance until the cycle after the result is
// taken, so a new request waits until the last result is taken;
// a stalled receiver simply holds the result.
// reset restores the register defaults (offsets 40 and 131, fan start
// 5000, full duty 3838), voltage phase, gain code 3, held values zero.
// configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) must come only
// while the block is idle with no result waiting.
module power_meter_autorange_step_top #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [15:0] voltage_mv_o,
  output logic signed [18:0] current_ma_o,
  output logic signed [23:0] power_mw_o,
  output logic [15:0]        fan_duty_o,
  output logic               next_channel_o,
  output logic [1:0]         next_gain_code_o,
  output logic               voltage_changed_o,
  output logic               current_changed_o,
  output logic               power_changed_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_REC  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_CORR = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] st_q, st_d;
  pmas_pkg::mul_sel_e op_q, op_d;
  logic [7:0] vofs_q, iofs_q;
  logic [15:0] fstart_q, ffull_q;
  logic phase_q;
  logic [1:0] gain_q;
  logic signed [16:0] hv_q;
  logic signed [18:0] hi_q;
  logic signed [23:0] hp_q;
  logic [15:0] hd_q;
  logic [24:0] mag_q;
  logic neg_q;
  logic vch_q, ich_q, pch_q;
  logic nch_q;
  logic [1:0] ngain_q;
  logic [47:0] num_q;
  logic [31:0] qest_q;

  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic div_start;
  logic [16:0] div_den;
  logic div_done;
  logic [31:0] quo;

  logic signed [SAMPLE_BITS:0] sx;
  logic signed [SAMPLE_BITS+1:0] dv;
  logic accept;

  assign accept = valid_i && ready_o;
  assign ready_o = (st_q == S_IDLE);
  assign valid_o = (st_q == S_OUT);
  assign sx = {sample_i[SAMPLE_BITS-1], sample_i};
  assign dv = {sx[SAMPLE_BITS], sx} -
              {{(SAMPLE_BITS-6){1'b0}}, (phase_q ? iofs_q : vofs_q)};

  // saturated results of each quotient
  logic [16:0] vsat;
  logic [18:0] isat;
  logic [23:0] psat;
  logic [15:0] dsat;
  logic signed [16:0] vnew;
  logic signed [18:0] inew;
  logic signed [23:0] pnew;
  logic pneg;
  logic [24:0] hp_mag;
  logic [1:0] gnew;

  assign vsat = (quo > 32'd32000) ? 17'd32000 : quo[16:0];
  assign isat = (quo > 32'd180000) ? 19'd180000 : quo[18:0];
  assign psat = (quo > 32'd5760000) ? 24'd5760000 : quo[23:0];
  assign dsat = (quo > {16'd0, ffull_q}) ? ffull_q : quo[15:0];
  assign pneg = hv_q[16] ^ hi_q[18];
  assign vnew = neg_q ? -$signed(vsat) : $signed(vsat);
  assign inew = neg_q ? -$signed(isat) : $signed(isat);
  assign pnew = pneg ? -$signed(psat) : $signed(psat);
  assign hp_mag = hp_q[23] ? 25'(-{hp_q[23], hp_q}) : {1'b0, hp_q};

  always_comb begin
    if (quo < 32'd256) gnew = 2'd3;
    else if (quo < 32'd512) gnew = 2'd2;
    else if (quo < 32'd1024) gnew = 2'd1;
    else if (quo <= 32'd2048) gnew = 2'd0;
    else gnew = gain_q;
  end

  // multiplier operand mux
  logic [16:0] hv_mag;
  logic [18:0] hi_mag;
  assign hv_mag = hv_q[16] ? 17'(-hv_q) : 17'(hv_q);
  assign hi_mag = hi_q[18] ? 19'(-hi_q) : 19'(hi_q);
  assign div_den = pmas_pkg::op_den(op_q, gain_q);

  always_comb begin
    unique case (st_q)
      S_REC: begin
        // numerator stays below 2^41, so bits 40:9 carry all of it
        ma = mp[40:9];
        mb = pmas_pkg::op_recip(op_q, gain_q);
      end
      S_REM: begin
        ma = mp[63:32];
        mb = 32'(div_den);
      end
      default: begin
        unique case (op_q)
          pmas_pkg::MUL_CURR: begin
            ma = 32'(mag_q);
            mb = 32'(pmas_pkg::curr_num(gain_q));
          end
          pmas_pkg::MUL_POWER: begin
            ma = 32'(hv_mag);
            mb = 32'(hi_mag);
          end
          pmas_pkg::MUL_DUTY: begin
            ma = 32'(hp_mag);
            mb = 32'(ffull_q);
          end
          pmas_pkg::MUL_GAIN: begin
            ma = 32'(mag_q) + 32'(iofs_q);
            mb = 32'(12'd2048 >> gain_q);
          end
          default: begin
            ma = 32'(mag_q);
            mb = 32'(pmas_pkg::V_NUM);
          end
        endcase
      end
    endcase
  end

  pmas_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(mp));

  assign div_start = (st_q == S_FIX);

  pmas_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(num_q), .prod_i(mp[47:0]), .quo_i(qest_q), .den_i(div_den),
    .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    st_d = st_q;
    op_d = op_q;
    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          st_d = S_MUL;
          op_d = phase_q ? pmas_pkg::MUL_CURR : pmas_pkg::MUL_VOLT;
        end
      end
      S_MUL: st_d = S_REC;
      S_REC: st_d = S_REM;
      S_REM: st_d = S_FIX;
      S_FIX: st_d = S_CORR;
      S_CORR: begin
        if (div_done) begin
          unique case (op_q)
            pmas_pkg::MUL_CURR: begin
              st_d = S_MUL;
              op_d = pmas_pkg::MUL_POWER;
            end
            pmas_pkg::MUL_POWER: begin
              st_d = S_MUL;
              op_d = pmas_pkg::MUL_DUTY;
            end
            pmas_pkg::MUL_DUTY: begin
              st_d = S_MUL;
              op_d = pmas_pkg::MUL_GAIN;
            end
            default: st_d = S_OUT;
          endcase
        end
      end
      S_OUT: if (ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      op_q <= pmas_pkg::MUL_VOLT;
      vofs_q <= 8'd40;
      iofs_q <= 8'd131;
      fstart_q <= 16'd5000;
      ffull_q <= 16'd3838;
      phase_q <= 1'b0;
      gain_q <= 2'd3;
      hv_q <= '0;
      hi_q <= '0;
      hp_q <= '0;
      hd_q <= '0;
      vch_q <= 1'b0;
      ich_q <= 1'b0;
      pch_q <= 1'b0;
      nch_q <= 1'b0;
      ngain_q <= 2'd0;
    end else begin
      st_q <= st_d;
      op_q <= op_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          2'(pmas_pkg::CFG_VOFS): vofs_q <= cfg_data_i[7:0];
          2'(pmas_pkg::CFG_IOFS): iofs_q <= cfg_data_i[7:0];
          2'(pmas_pkg::CFG_FSTART): fstart_q <= cfg_data_i;
          default: ffull_q <= cfg_data_i;
        endcase
      end
      if (accept) begin
        vch_q <= 1'b0;
        ich_q <= 1'b0;
        pch_q <= 1'b0;
      end
      if (st_q == S_CORR && div_done) begin
        unique case (op_q)
          pmas_pkg::MUL_VOLT: begin
            vch_q <= (vnew != hv_q);
            hv_q <= vnew;
            phase_q <= 1'b1;
            nch_q <= 1'b1;
            ngain_q <= gain_q;
          end
          pmas_pkg::MUL_CURR: begin
            ich_q <= (inew != hi_q);
            hi_q <= inew;
          end
          pmas_pkg::MUL_POWER: begin
            pch_q <= (pnew != hp_q);
            hp_q <= pnew;
          end
          pmas_pkg::MUL_DUTY: begin
            hd_q <= (hp_mag < {9'd0, fstart_q}) ? 16'd0 : dsat;
          end
          default: begin
            gain_q <= gnew;
            phase_q <= 1'b0;
            nch_q <= 1'b0;
            ngain_q <= 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= dv[SAMPLE_BITS+1];
      mag_q <= 25'(dv[SAMPLE_BITS+1] ? -dv : dv);
    end
    if (st_q == S_REC) num_q <= mp[47:0];
    if (st_q == S_REM) qest_q <= mp[63:32];
  end

  assign voltage_mv_o = hv_q[15:0];
  assign current_ma_o = hi_q;
  assign power_mw_o = hp_q;
  assign fan_duty_o = hd_q;
  assign next_channel_o = nch_q;
  assign next_gain_code_o = ngain_q;
  assign voltage_changed_o = vch_q;
  assign current_changed_o = ich_q;
  assign power_changed_o = pch_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o |-> !valid_o) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o) else $error("result dropped");
  a_volt_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !next_channel_o) |-> next_gain_code_o == 2'd0)
    else $error("voltage gain not one");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && next_channel_o) |-> (!current_changed_o && !power_changed_o))
    else $error("flags in voltage phase");
`endif
endmodule

// ===== tb/sv/tb_power_meter_autorange_step_top.sv =====
// testbench for the power meter autorange step block: predicted results vs. dut outputs
`timescale 1ns / 1ps
module tb_power_meter_autorange_step_top;

  localparam int unsigned WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic signed [15:0] mv;
    logic signed [18:0] ma;
    logic signed [23:0] mw;
    logic [15:0]        duty;
    logic               chan;
    logic [1:0]         gain;
    logic               vch;
    logic               ich;
    logic               pch;
  } meter_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic valid_i = 1'b0;
  logic ready_o;
  logic [15:0] sample_i = '0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic signed [15:0] voltage_mv_o;
  logic signed [18:0] current_ma_o;
  logic signed [23:0] power_mw_o;
  logic [15:0] fan_duty_o;
  logic next_channel_o;
  logic [1:0] next_gain_code_o;
  logic voltage_changed_o, current_changed_o, power_changed_o;

  power_meter_autorange_step_top dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  longint p_vofs, p_iofs, p_fstart, p_ffull;
  bit p_phase;
  logic [1:0] p_gain;
  longint p_volt, p_curr, p_pow, p_duty;

  logic [15:0] pending_samples[$];
  meter_out_t  expected_results[$];
  int errors = 0;
  bit quiet = 0;
  bit hold_sender = 0;
  bit in_taken = 0;
  int idle_in = 0, idle_out = 0;
  int stall_cycles = 0;

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic meter_out_t predict_meter(logic signed [15:0] smp);
    meter_out_t r;
    longint s, d, mag, v, i, p, pm, duty, t;
    s = smp;
    r = '0;
    if (!p_phase) begin
      d = s - p_vofs;
      mag = d < 0 ? -d : d;
      v = (mag * 97506) / 100000;
      if (d < 0) v = -v;
      v = clamp(v, 32000);
      r.vch = (v != p_volt);
      p_volt = v;
      p_phase = 1'b1;
      r.chan = 1'b1;
      r.gain = p_gain;
    end else begin
      d = s - p_iofs;
      mag = d < 0 ? -d : d;
      case (p_gain)
        2'd0: i = (mag * 54349) / 10000;
        2'd1: i = (mag * 27175) / 10000;
        2'd2: i = (mag * 13587) / 10000;
        default: i = (mag * 67937) / 100000;
      endcase
      if (d < 0) i = -i;
      i = clamp(i, 180000);
      r.ich = (i != p_curr);
      p_curr = i;
      p = clamp((p_volt * i) / 1000, 5760000);
      r.pch = (p != p_pow);
      p_pow = p;
      pm = p < 0 ? -p : p;
      if (pm < p_fstart) duty = 0;
      else begin
        duty = (pm * p_ffull) / 30000;
        if (duty > p_ffull) duty = p_ffull;
      end
      p_duty = duty;
      t = ((mag + p_iofs) * (2048 >> p_gain)) / 32767;
      if (t < 256) p_gain = 2'd3;
      else if (t < 512) p_gain = 2'd2;
      else if (t < 1024) p_gain = 2'd1;
      else if (t <= 2048) p_gain = 2'd0;
      p_phase = 1'b0;
      r.chan = 1'b0;
      r.gain = 2'd0;
    end
    r.mv = p_volt[15:0];
    r.ma = p_curr[18:0];
    r.mw = p_pow[23:0];
    r.duty = p_duty[15:0];
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !in_taken) begin
        // hold until the request is taken
      end else if (idle_in > 0) begin
        idle_in <= idle_in - 1;
        valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        idle_in <= $urandom_range(1, 13);
        valid_i <= 1'b0;
      end else if (!hold_sender && pending_samples.size() > 0) begin
        valid_i <= 1'b1;
        sample_i <= pending_samples[0];
      end else begin
        valid_i <= 1'b0;
      end
      in_taken = 1'b0;
      if (idle_out > 0) begin
        idle_out <= idle_out - 1;
        ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        idle_out <= $urandom_range(1, 13);
        ready_i <= 1'b0;
      end else begin
        ready_i <= 1'b1;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && ready_o) begin
        expected_results.push_back(predict_meter(sample_i));
        void'(pending_samples.pop_front());
        in_taken = 1'b1;
      end
      if ((valid_i && ready_o) || (valid_o && ready_i)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog expired", $time);
        $display("RESULT: ERROR");
        $finish;
      end
      if (valid_o && ready_i) begin
        meter_out_t got, want;
        got = '{voltage_mv_o, current_ma_o, power_mw_o, fan_duty_o, next_channel_o,
                next_gain_code_o, voltage_changed_o, current_changed_o, power_changed_o};
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.mv !== want.mv || got.ma !== want.ma || got.mw !== want.mw
              || got.duty !== want.duty || got.chan !== want.chan
              || got.gain !== want.gain || got.vch !== want.vch
              || got.ich !== want.ich || got.pch !== want.pch) begin
            $display("%0t mismatch expected mv=%0d ma=%0d mw=%0d duty=%0d ch=%0d g=%0d fl=%b%b%b",
                     $time, want.mv, want.ma, want.mw, want.duty, want.chan, want.gain,
                     want.vch, want.ich, want.pch);
            $display("%0t          actual   mv=%0d ma=%0d mw=%0d duty=%0d ch=%0d g=%0d fl=%b%b%b",
                     $time, got.mv, got.ma, got.mw, got.duty, got.chan, got.gain,
                     got.vch, got.ich, got.pch);
            errors++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_reg(int unsigned idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[1:0];
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pmas_pkg::CFG_VOFS: p_vofs = val[7:0];
      pmas_pkg::CFG_IOFS: p_iofs = val[7:0];
      pmas_pkg::CFG_FSTART: p_fstart = val;
      default: p_ffull = val;
    endcase
  endtask

  // random samples, each any 16-bit value, within 300 of the current offset, 0 to 33000, or offset plus up to 2^k
  task automatic add_random(int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0: pending_samples.push_back(16'($urandom));
        1: pending_samples.push_back(16'($signed($urandom_range(0, 600)) - 300 + p_iofs));
        2: pending_samples.push_back(16'($urandom_range(0, 33000)));
        default: pending_samples.push_back(16'($signed(p_iofs)
                   + $signed(16'($urandom_range(0, 1 << $urandom_range(1, 15))))));
      endcase
    end
  endtask

  initial begin
    p_vofs = 40; p_iofs = 131; p_fstart = 5000; p_ffull = 3838;
    p_phase = 0; p_gain = 3;
    p_volt = 0; p_curr = 0; p_pow = 0; p_duty = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, saturation, gain walk, zero power
    pending_samples = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'd40, 16'd131,
                        16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd20000, 16'd3000,
                        16'd20000, 16'd6000, 16'd20000, 16'd12000, 16'd20000, 16'd25000,
                        16'hFFFF, 16'd200, 16'd10000, 16'd131};
    wait_drained();
    // sender holds off while twenty samples are queued, then is released
    hold_sender = 1;
    add_random(20);
    repeat (30) @(posedge clk_i);
    hold_sender = 0;
    wait_drained();

    write_reg(pmas_pkg::CFG_VOFS, 16'd255);
    write_reg(pmas_pkg::CFG_IOFS, 16'd0);
    write_reg(pmas_pkg::CFG_FSTART, 16'd0);
    write_reg(pmas_pkg::CFG_FFULL, 16'hFFFF);
    add_random(130);
    wait_drained();

    write_reg(pmas_pkg::CFG_VOFS, 16'd0);
    write_reg(pmas_pkg::CFG_IOFS, 16'd255);
    write_reg(pmas_pkg::CFG_FSTART, 16'hFFFF);
    write_reg(pmas_pkg::CFG_FFULL, 16'd0);
    add_random(100);
    wait_drained();

    write_reg(pmas_pkg::CFG_VOFS, 16'($urandom_range(0, 255)));
    write_reg(pmas_pkg::CFG_IOFS, 16'($urandom_range(0, 255)));
    write_reg(pmas_pkg::CFG_FSTART, 16'($urandom_range(0, 20000)));
    write_reg(pmas_pkg::CFG_FFULL, 16'($urandom));
    add_random(120);
    wait_drained();

    quiet = 1;
    add_random(60);
    wait_drained();

    if (errors == 0 && expected_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/pmas_pkg.sv
design/pmas_mul.sv
design/pmas_div.sv
design/power_meter_autorange_step_top.sv
tb/sv/tb_power_meter_autorange_step_top.sv
